[rtl/core/llc_pkg.sv]
// shared constants and types for the lead/lag compensator
package llc_pkg;

   // default sample width and configuration word layout
   localparam int DATA_WIDTH_DEF = 32;
   localparam int CSR_W          = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int RATIO_W        = 24;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SAMPLE_TIME = 2'd0;
   localparam csr_idx_type CSR_CORNER_FREQ = 2'd1;
   localparam csr_idx_type CSR_PHASE_RATIO = 2'd2;

   localparam logic [CSR_W-1:0]   SAMPLE_TIME_RST = 32'd429497;
   localparam logic [CSR_W-1:0]   CORNER_FREQ_RST = 32'd25600;
   localparam logic [RATIO_W-1:0] PHASE_RATIO_RST = 24'd65536;

   // request action codes
   localparam logic ACT_CLEAR = 1'b1;

   // scaled equation: num = u(P+Q) + u1(P-Q) - y1(P-R), den = P+R
   // with P = Ts*g, Q = a << Q_SHIFT, R = 1 << R_SHIFT
   localparam int Q_SHIFT = 25;
   localparam int R_SHIFT = 41;

   // den < 2^65, divider remainder needs one more bit
   localparam int DEN_W = 65;
   localparam int REM_W = 66;

   // numerator magnitude plus sign, quotient field of DATA_WIDTH+1 bits
   localparam int NUM_W_DEF = DATA_WIDTH_DEF + 1 + REM_W;

endpackage

[rtl/core/llc_addsub.sv]
// shared add/subtract unit with unsigned compare flag
module llc_addsub #(
   parameter int WIDTH = llc_pkg::NUM_W_DEF
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] sum,
   output logic             ge
);

   logic [WIDTH:0] full;

   assign full = {1'b0, op_a} + {1'b0, op_b ^ {WIDTH{sub}}} + {{WIDTH{1'b0}}, sub};
   assign sum  = full[WIDTH-1:0];
   // carry out of a - b means a >= b
   assign ge   = full[WIDTH];

endmodule

[rtl/core/lead_lag_compensator.sv]
// first-order lead/lag compensator, bilinear form, on one shared adder
// a filter word runs the multiplies, the negate, the overflow check, the divide and the rounding
//   in turn before rsp_valid; an early quotient overflow skips the divide, a clear skips all of them
// a new word is stalled until the sequencer is idle again; the serial shift-add multiplies and the
//   restoring divide all run through the one adder, one bit per cycle
// reset: synchronous, clears stored input/output, loads register defaults, outputs idle
module lead_lag_compensator #(
   parameter int DATA_WIDTH = llc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [DATA_WIDTH-1:0]        req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_filtered,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  llc_pkg::csr_idx_type                csr_index,
   input  logic [llc_pkg::CSR_W-1:0]           csr_data
);

   localparam int NUM_W = DATA_WIDTH + 1 + llc_pkg::REM_W;
   localparam int LOW_W = DATA_WIDTH + 1;
   localparam int MPL_W = (DATA_WIDTH + 1 > llc_pkg::CSR_W) ? DATA_WIDTH + 1 : llc_pkg::CSR_W;
   localparam int CNT_W = $clog2(MPL_W);
   localparam int DEN_W = llc_pkg::DEN_W;
   localparam int REM_W = llc_pkg::REM_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MULP = 4'd1;
   localparam logic [3:0] ST_PEND = 4'd2;
   localparam logic [3:0] ST_MULS = 4'd3;
   localparam logic [3:0] ST_MULQ = 4'd4;
   localparam logic [3:0] ST_NEG  = 4'd5;
   localparam logic [3:0] ST_CHK  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_RND1 = 4'd8;
   localparam logic [3:0] ST_RND2 = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;

   localparam logic [DATA_WIDTH-1:0] Y_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] Y_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH+1:0] Q_LIM = (DATA_WIDTH+2)'(1) << (DATA_WIDTH-1);

   logic [3:0]                   state_ff, state_in;
   logic [NUM_W-1:0]             acc_ff, acc_in;
   logic [NUM_W-1:0]             mcand_ff, mcand_in;
   logic [MPL_W-1:0]             mplier_ff, mplier_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         mul_neg_ff, mul_neg_in;
   logic                         nneg_ff, nneg_in;
   logic                         round_ff, round_in;
   logic [DEN_W-1:0]             d_ff, d_in;
   logic [DATA_WIDTH-1:0]        u_ff, u_in;
   logic [DATA_WIDTH-1:0]        last_in_ff, last_in_in;
   logic [DATA_WIDTH-1:0]        last_out_ff, last_out_in;
   logic                         sat_ff, sat_in;
   logic [llc_pkg::CSR_W-1:0]    ts_ff, ts_in;
   logic [llc_pkg::CSR_W-1:0]    fc_ff, fc_in;
   logic [llc_pkg::RATIO_W-1:0]  pr_ff, pr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]        rsp_filtered_ff, rsp_filtered_in;
   logic                         rsp_saturated_ff, rsp_saturated_in;

   logic [NUM_W-1:0]             op_a, op_b, alu_sum;
   logic                         op_sub, alu_ge;

   logic [DATA_WIDTH+1:0]        s_sum, s_abs;
   logic                         s_neg;
   logic [DATA_WIDTH:0]          diff, diff_abs;
   logic                         diff_neg;
   logic [DATA_WIDTH+1:0]        q_rnd;
   logic                         q_big, q_at_lim, q_sat;

   llc_addsub #(
      .WIDTH (NUM_W)
   ) u_addsub (
      .op_a (op_a),
      .op_b (op_b),
      .sub  (op_sub),
      .sum  (alu_sum),
      .ge   (alu_ge)
   );

   // multiplier operands: |u + u1 - y1| and |u - u1|
   always_comb begin
      s_sum    = {{2{u_ff[DATA_WIDTH-1]}}, u_ff}
               + {{2{last_in_ff[DATA_WIDTH-1]}}, last_in_ff}
               - {{2{last_out_ff[DATA_WIDTH-1]}}, last_out_ff};
      s_neg    = s_sum[DATA_WIDTH+1];
      s_abs    = s_neg ? (~s_sum + 1'b1) : s_sum;
      diff     = {u_ff[DATA_WIDTH-1], u_ff} - {last_in_ff[DATA_WIDTH-1], last_in_ff};
      diff_neg = diff[DATA_WIDTH];
      diff_abs = diff_neg ? (~diff + 1'b1) : diff;
   end

   // rounded quotient and saturation
   always_comb begin
      q_rnd    = alu_sum[DATA_WIDTH+1:0];
      q_big    = |q_rnd[DATA_WIDTH+1:DATA_WIDTH-1];
      q_at_lim = (q_rnd == Q_LIM);
      q_sat    = nneg_ff ? (q_big && !q_at_lim) : q_big;
   end

   // shared adder operand select
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      case (state_ff)
         ST_MULP, ST_MULS, ST_MULQ: begin
            op_a   = acc_ff;
            op_b   = mcand_ff;
            op_sub = mul_neg_ff;
         end
         ST_PEND: begin
            op_a = acc_ff;
            op_b = NUM_W'(1) << llc_pkg::R_SHIFT;
         end
         ST_NEG: begin
            op_b   = acc_ff;
            op_sub = 1'b1;
         end
         ST_CHK: begin
            op_a   = NUM_W'(acc_ff[NUM_W-1:LOW_W]);
            op_b   = NUM_W'(d_ff);
            op_sub = 1'b1;
         end
         ST_DIV: begin
            op_a   = NUM_W'(acc_ff[NUM_W-2:DATA_WIDTH]);
            op_b   = NUM_W'(d_ff);
            op_sub = 1'b1;
         end
         ST_RND1: begin
            op_a   = NUM_W'({acc_ff[NUM_W-2:LOW_W], 1'b0});
            op_b   = NUM_W'(d_ff);
            op_sub = 1'b1;
         end
         ST_RND2: begin
            op_a = NUM_W'(acc_ff[DATA_WIDTH:0]);
            op_b = NUM_W'(round_ff);
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      acc_in           = acc_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      cnt_in           = cnt_ff;
      mul_neg_in       = mul_neg_ff;
      nneg_in          = nneg_ff;
      round_in         = round_ff;
      d_in             = d_ff;
      u_in             = u_ff;
      last_in_in       = last_in_ff;
      last_out_in      = last_out_ff;
      sat_in           = sat_ff;
      ts_in            = ts_ff;
      fc_in            = fc_ff;
      pr_in            = pr_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_saturated_in = rsp_saturated_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            llc_pkg::CSR_SAMPLE_TIME: ts_in = csr_data;
            llc_pkg::CSR_CORNER_FREQ: fc_in = csr_data;
            llc_pkg::CSR_PHASE_RATIO: pr_in = csr_data[llc_pkg::RATIO_W-1:0];
            default:                  ts_in = ts_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == llc_pkg::ACT_CLEAR) begin
                  last_in_in  = '0;
                  last_out_in = '0;
                  sat_in      = 1'b0;
                  state_in    = ST_FIN;
               end else begin
                  u_in       = req_sample;
                  acc_in     = '0;
                  mcand_in   = NUM_W'(ts_ff);
                  mplier_in  = MPL_W'(fc_ff);
                  mul_neg_in = 1'b0;
                  cnt_in     = CNT_W'(llc_pkg::CSR_W - 1);
                  state_in   = ST_MULP;
               end
            end
         end
         ST_MULP, ST_MULS, ST_MULQ: begin
            if (mplier_ff[0]) begin
               acc_in = alu_sum;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               case (state_ff)
                  ST_MULP: state_in = ST_PEND;
                  ST_MULS: begin
                     mcand_in   = NUM_W'(pr_ff) << llc_pkg::Q_SHIFT;
                     mplier_in  = MPL_W'(diff_abs);
                     mul_neg_in = diff_neg;
                     cnt_in     = CNT_W'(DATA_WIDTH);
                     state_in   = ST_MULQ;
                  end
                  default: state_in = ST_NEG;
               endcase
            end
         end
         ST_PEND: begin
            // acc holds P; keep it as multiplicand, den = P + R, seed with R*y1
            mcand_in   = acc_ff;
            d_in       = alu_sum[DEN_W-1:0];
            acc_in     = {{(NUM_W-DATA_WIDTH-llc_pkg::R_SHIFT){last_out_ff[DATA_WIDTH-1]}},
                          last_out_ff, {llc_pkg::R_SHIFT{1'b0}}};
            mplier_in  = MPL_W'(s_abs[DATA_WIDTH:0]);
            mul_neg_in = s_neg;
            cnt_in     = CNT_W'(DATA_WIDTH);
            state_in   = ST_MULS;
         end
         ST_NEG: begin
            nneg_in = acc_ff[NUM_W-1];
            if (acc_ff[NUM_W-1]) begin
               acc_in = alu_sum;
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // quotient of 2^(DATA_WIDTH+1) or more always clips
            if (alu_ge) begin
               sat_in      = 1'b1;
               last_out_in = nneg_ff ? Y_MIN : Y_MAX;
               last_in_in  = u_ff;
               state_in    = ST_FIN;
            end else begin
               cnt_in   = CNT_W'(DATA_WIDTH);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in = {alu_ge ? alu_sum[REM_W-1:0] : acc_ff[NUM_W-2:DATA_WIDTH],
                      acc_ff[DATA_WIDTH-1:0], alu_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_RND1;
            end
         end
         ST_RND1: begin
            round_in = alu_ge;
            state_in = ST_RND2;
         end
         ST_RND2: begin
            sat_in = q_sat;
            if (q_sat) begin
               last_out_in = nneg_ff ? Y_MIN : Y_MAX;
            end else if (nneg_ff) begin
               last_out_in = ~q_rnd[DATA_WIDTH-1:0] + 1'b1;
            end else begin
               last_out_in = q_rnd[DATA_WIDTH-1:0];
            end
            last_in_in = u_ff;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = last_out_ff;
               rsp_saturated_in = sat_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_in_ff   <= '0;
         last_out_ff  <= '0;
         ts_ff        <= llc_pkg::SAMPLE_TIME_RST;
         fc_ff        <= llc_pkg::CORNER_FREQ_RST;
         pr_ff        <= llc_pkg::PHASE_RATIO_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_in_ff   <= last_in_in;
         last_out_ff  <= last_out_in;
         ts_ff        <= ts_in;
         fc_ff        <= fc_in;
         pr_ff        <= pr_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff           <= acc_in;
      mcand_ff         <= mcand_in;
      mplier_ff        <= mplier_in;
      cnt_ff           <= cnt_in;
      mul_neg_ff       <= mul_neg_in;
      nneg_ff          <= nneg_in;
      round_ff         <= round_in;
      d_ff             <= d_in;
      u_ff             <= u_in;
      sat_ff           <= sat_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // divider remainder stays below the denominator
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_RND1)
         |-> (acc_ff[NUM_W-1:LOW_W] < REM_W'(d_ff)))
      else $error("divider remainder not below denominator");

   // denominator carries the 2^41 term once formed
   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK || state_ff == ST_DIV || state_ff == ST_RND1)
         |-> (|d_ff[DEN_W-1:llc_pkg::R_SHIFT]))
      else $error("denominator below 2^41");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result word loaded outside final state");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff)
         |-> (rsp_filtered_ff == Y_MAX || rsp_filtered_ff == Y_MIN))
      else $error("saturated word not at a limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word left sequencer idle");

endmodule
